@@ design/svx_pkg.sv @@
package svx_pkg;

  localparam int COORD_W = 24;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int NORM_W  = PROD_W + 1;
  localparam int SPLIT_W = 24;
  localparam int NH_W    = NORM_W - SPLIT_W;
  localparam int LIGHT_W = 16;
  localparam int DIST_W  = 16;
  localparam int PH_W    = NH_W + LIGHT_W;
  localparam int PL_W    = SPLIT_W + 1 + LIGHT_W;
  localparam int HI_W    = PH_W + 2;
  localparam int LO_W    = PL_W + 2;
  localparam int DOT_W   = HI_W + SPLIT_W;
  localparam int OPROD_W = LIGHT_W + DIST_W + 1;
  localparam int OFF_W   = OPROD_W - 2;
  localparam int OUT_W   = 32;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;
  localparam logic [CFG_AW-1:0] CFG_LIGHT_X  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LIGHT_Y  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_LIGHT_Z  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_DISTANCE = 2'd3;

  localparam logic signed [LIGHT_W-1:0] LIGHT_X_RST = 16'sd23170;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Y_RST = 16'sd23170;
  localparam logic signed [LIGHT_W-1:0] LIGHT_Z_RST = 16'sd0;
  localparam logic [DIST_W-1:0]         DIST_RST    = 16'd10000;

  // edge index of the closing edge (p2,p0)
  localparam logic [1:0] SIDE_LAST = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } vtx_t;

  typedef struct packed {
    vtx_t v2;
    vtx_t v1;
    vtx_t v0;
  } tri_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] x;
  } ovtx_t;

  typedef struct packed {
    logic signed [LIGHT_W-1:0] z;
    logic signed [LIGHT_W-1:0] y;
    logic signed [LIGHT_W-1:0] x;
  } light_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] z;
    logic signed [OFF_W-1:0] y;
    logic signed [OFF_W-1:0] x;
  } off_t;

  // classified triangle handed from front to back
  typedef struct packed {
    tri_t corners;
    logic last;
    logic extrude;
  } qent_t;

  // position within one six-vertex quad: a, b, a', b, b', a'
  typedef enum logic [2:0] {
    SLOT_A,
    SLOT_B,
    SLOT_AE,
    SLOT_B2,
    SLOT_BE,
    SLOT_AE2
  } slot_t;

  function automatic vtx_t pick_vtx(tri_t t, logic [1:0] idx);
    vtx_t v;
    case (idx)
      2'd0:    v = t.v0;
      2'd1:    v = t.v1;
      default: v = t.v2;
    endcase
    return v;
  endfunction

endpackage

@@ design/shadow_volume_extruder.sv @@
// Channel | Dir | tdata (low bit up)                     | tlast         | tuser
// in_     | in  | v0_x v0_y v0_z v1_x .. v2_z, 24b each  | last_triangle | -
// out_    | out | out_x out_y out_z, 32b each            | run_last      | vertex_valid,
//         |     |                                        |               | mesh_done
// cfg_    | in  | cfg_addr 0..3: light_x/y/z, extrude_distance; cfg_wdata 16b
//
// Classification pipeline registers d1/d2, m, n, ph/pl and hi/lo in turn; a triangle can
// enter every cycle while in_tready is high. The output register emits one vertex per
// cycle while out_tready is high: 18 vertices per extruded triangle, one end marker for a
// culled last triangle, none for other culled triangles; the output port sets the rate.
// rst_n (synchronous) clears all valid state and loads the default light setup.
// A stalled output holds its register; the 4-entry queue then fills and
// in_tready drops once the front pipeline has a triangle it cannot hand over.
module shadow_volume_extruder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
  input  logic [9*svx_pkg::COORD_W-1:0] in_tdata,
  input  logic                          in_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // out_x, out_y, out_z
  output logic [3*svx_pkg::OUT_W-1:0]   out_tdata,
  output logic                          out_tlast,
  // vertex_valid, mesh_done
  output logic [1:0]                    out_tuser,
  input  logic                          cfg_we,
  input  logic [svx_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [svx_pkg::CFG_DW-1:0]    cfg_wdata
);
  import svx_pkg::*;

  light_t               light_r;
  logic [DIST_W-1:0]    dist_r;
  off_t                 off_r;
  logic signed [OPROD_W-1:0] oprod [0:2];
  logic signed [OPROD_W:0]   orsum [0:2];

  logic  push_valid, push_ready;
  qent_t push_ent, head;
  logic  q_valid, q_pop;
  ovtx_t out_vtx;
  logic  vv, done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r.x <= LIGHT_X_RST;
      light_r.y <= LIGHT_Y_RST;
      light_r.z <= LIGHT_Z_RST;
      dist_r    <= DIST_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LIGHT_X:  light_r.x <= $signed(cfg_wdata);
        CFG_LIGHT_Y:  light_r.y <= $signed(cfg_wdata);
        CFG_LIGHT_Z:  light_r.z <= $signed(cfg_wdata);
        CFG_DISTANCE: dist_r    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // offset = round(light * distance) from Q.15 to Q.12, ties up
  assign oprod[0] = light_r.x * $signed({1'b0, dist_r});
  assign oprod[1] = light_r.y * $signed({1'b0, dist_r});
  assign oprod[2] = light_r.z * $signed({1'b0, dist_r});
  for (genvar c = 0; c < 3; c++) begin : g_round
    assign orsum[c] = (OPROD_W+1)'(oprod[c]) + (OPROD_W+1)'(4);
  end

  always_ff @(posedge clk) begin
    off_r.x <= orsum[0][OPROD_W:3];
    off_r.y <= orsum[1][OPROD_W:3];
    off_r.z <= orsum[2][OPROD_W:3];
  end

  svx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_tri     (tri_t'(in_tdata)),
    .in_last    (in_tlast),
    .light      (light_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ent   (push_ent)
  );

  svx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_ent   (push_ent),
    .head_valid (q_valid),
    .head       (head),
    .pop        (q_pop)
  );

  svx_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_valid),
    .head             (head),
    .pop              (q_pop),
    .off              (off_r),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_vtx          (out_vtx),
    .out_last         (out_tlast),
    .out_vertex_valid (vv),
    .out_mesh_done    (done)
  );

  assign out_tdata = out_vtx;
  assign out_tuser = {done, vv};

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tuser[1] && out_tdata == '0)
    else $error("malformed end marker");

  a_done_on_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("mesh_done without run_last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

@@ design/svx_front.sv @@
module svx_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  svx_pkg::tri_t  in_tri,
  input  logic           in_last,
  input  svx_pkg::light_t light,
  output logic           push_valid,
  input  logic           push_ready,
  output svx_pkg::qent_t push_ent
);
  import svx_pkg::*;

  logic [4:0] vld_r;
  tri_t       tri_r  [0:4];
  logic       last_r [0:4];

  logic signed [DIFF_W-1:0] d1_r [0:2];
  logic signed [DIFF_W-1:0] d2_r [0:2];
  logic signed [PROD_W-1:0] m_r  [0:5];
  logic signed [NORM_W-1:0] n_r  [0:2];
  logic signed [PH_W-1:0]   ph_r [0:2];
  logic signed [PL_W-1:0]   pl_r [0:2];
  logic signed [HI_W-1:0]   hi_r;
  logic signed [LO_W-1:0]   lo_r;

  logic signed [COORD_W-1:0] p0c [0:2];
  logic signed [COORD_W-1:0] p1c [0:2];
  logic signed [COORD_W-1:0] p2c [0:2];
  logic signed [LIGHT_W-1:0] lt  [0:2];
  logic [DOT_W-1:0]          dot;
  logic                      away;
  logic                      need;
  logic                      adv;

  assign p0c[0] = in_tri.v0.x;
  assign p0c[1] = in_tri.v0.y;
  assign p0c[2] = in_tri.v0.z;
  assign p1c[0] = in_tri.v1.x;
  assign p1c[1] = in_tri.v1.y;
  assign p1c[2] = in_tri.v1.z;
  assign p2c[0] = in_tri.v2.x;
  assign p2c[1] = in_tri.v2.y;
  assign p2c[2] = in_tri.v2.z;
  assign lt[0]  = light.x;
  assign lt[1]  = light.y;
  assign lt[2]  = light.z;

  // dot = hi * 2^24 + lo, exact
  assign dot  = {hi_r, {SPLIT_W{1'b0}}} + {{(DOT_W-LO_W){lo_r[LO_W-1]}}, lo_r};
  assign away = dot[DOT_W-1] || (dot == '0);
  // culled triangles that are not last leave no trace downstream
  assign need = away || last_r[4];
  assign adv  = !vld_r[4] || !need || push_ready;

  assign in_ready   = adv;
  assign push_valid = vld_r[4] && need;
  assign push_ent   = '{corners: tri_r[4], last: last_r[4], extrude: away};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tri_r[0]  <= in_tri;
      last_r[0] <= in_last;
      for (int i = 1; i < 5; i++) begin
        tri_r[i]  <= tri_r[i-1];
        last_r[i] <= last_r[i-1];
      end
      for (int c = 0; c < 3; c++) begin
        d1_r[c] <= DIFF_W'(p2c[c]) - DIFF_W'(p1c[c]);
        d2_r[c] <= DIFF_W'(p1c[c]) - DIFF_W'(p0c[c]);
      end
      m_r[0] <= d1_r[1] * d2_r[2];
      m_r[1] <= d1_r[2] * d2_r[1];
      m_r[2] <= d1_r[2] * d2_r[0];
      m_r[3] <= d1_r[0] * d2_r[2];
      m_r[4] <= d1_r[0] * d2_r[1];
      m_r[5] <= d1_r[1] * d2_r[0];
      for (int c = 0; c < 3; c++) begin
        n_r[c]  <= NORM_W'(m_r[2*c]) - NORM_W'(m_r[2*c+1]);
        ph_r[c] <= $signed(n_r[c][NORM_W-1:SPLIT_W]) * lt[c];
        pl_r[c] <= $signed({1'b0, n_r[c][SPLIT_W-1:0]}) * lt[c];
      end
      hi_r <= HI_W'(ph_r[0]) + HI_W'(ph_r[1]) + HI_W'(ph_r[2]);
      lo_r <= LO_W'(pl_r[0]) + LO_W'(pl_r[1]) + LO_W'(pl_r[2]);
    end
  end

endmodule

@@ design/svx_queue.sv @@
module svx_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  svx_pkg::qent_t push_ent,
  output logic           head_valid,
  output svx_pkg::qent_t head,
  input  logic           pop
);
  import svx_pkg::*;

  qent_t           ent_r [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_AW:0]   cnt_r;
  logic            push;

  assign push_ready = (cnt_r != (Q_AW+1)'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = ent_r[rd_r];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + Q_AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (Q_AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (Q_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_r] <= push_ent;
    end
  end

endmodule

@@ design/svx_back.sv @@
module svx_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  svx_pkg::qent_t head,
  output logic           pop,
  input  svx_pkg::off_t  off,
  output logic           out_valid,
  input  logic           out_ready,
  output svx_pkg::ovtx_t out_vtx,
  output logic           out_last,
  output logic           out_vertex_valid,
  output logic           out_mesh_done
);
  import svx_pkg::*;

  slot_t      slot_r, slot_nxt;
  logic [1:0] side_r, side_nxt;

  logic  out_valid_r;
  ovtx_t vtx_r, vtx_nxt;
  logic  last_r, last_nxt;
  logic  vv_r, vv_nxt;
  logic  done_r, done_nxt;

  logic       load, issue, final_vtx;
  logic [1:0] a_idx, b_idx, v_idx;
  logic       ext;
  vtx_t       vsel;

  assign load      = !out_valid_r || out_ready;
  assign issue     = head_valid && load;
  assign final_vtx = !head.extrude || (side_r == SIDE_LAST && slot_r == SLOT_AE2);
  assign pop       = issue && final_vtx;

  always_comb begin
    slot_nxt = slot_r;
    side_nxt = side_r;
    if (issue) begin
      if (final_vtx) begin
        slot_nxt = SLOT_A;
        side_nxt = '0;
      end else begin
        case (slot_r)
          SLOT_A:  slot_nxt = SLOT_B;
          SLOT_B:  slot_nxt = SLOT_AE;
          SLOT_AE: slot_nxt = SLOT_B2;
          SLOT_B2: slot_nxt = SLOT_BE;
          SLOT_BE: slot_nxt = SLOT_AE2;
          SLOT_AE2: begin
            slot_nxt = SLOT_A;
            side_nxt = side_r + 2'd1;
          end
          default: slot_nxt = SLOT_A;
        endcase
      end
    end
  end

  assign a_idx = side_r;
  assign b_idx = (side_r == SIDE_LAST) ? 2'd0 : side_r + 2'd1;

  always_comb begin
    case (slot_r)
      SLOT_A:   begin v_idx = a_idx; ext = 1'b0; end
      SLOT_B:   begin v_idx = b_idx; ext = 1'b0; end
      SLOT_AE:  begin v_idx = a_idx; ext = 1'b1; end
      SLOT_B2:  begin v_idx = b_idx; ext = 1'b0; end
      SLOT_BE:  begin v_idx = b_idx; ext = 1'b1; end
      SLOT_AE2: begin v_idx = a_idx; ext = 1'b1; end
      default:  begin v_idx = a_idx; ext = 1'b0; end
    endcase
    vsel = pick_vtx(head.corners, v_idx);
    if (head.extrude) begin
      vtx_nxt.x = OUT_W'(vsel.x) - (ext ? OUT_W'(off.x) : '0);
      vtx_nxt.y = OUT_W'(vsel.y) - (ext ? OUT_W'(off.y) : '0);
      vtx_nxt.z = OUT_W'(vsel.z) - (ext ? OUT_W'(off.z) : '0);
      vv_nxt    = 1'b1;
      last_nxt  = final_vtx;
      done_nxt  = final_vtx && head.last;
    end else begin
      // end-of-mesh marker for a culled last triangle
      vtx_nxt   = '0;
      vv_nxt    = 1'b0;
      last_nxt  = 1'b1;
      done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= SLOT_A;
      side_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      side_r <= side_nxt;
      if (load) begin
        out_valid_r <= issue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      vtx_r  <= vtx_nxt;
      last_r <= last_nxt;
      vv_r   <= vv_nxt;
      done_r <= done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_vtx          = vtx_r;
  assign out_last         = last_r;
  assign out_vertex_valid = vv_r;
  assign out_mesh_done    = done_r;

endmodule

@@ dv/shadow_volume_extruder_tb.sv @@
module shadow_volume_extruder_tb;
  import svx_pkg::*;

  localparam int LO = -8388608;
  localparam int HI = 8388607;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 24;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_TRIS = 17;
  localparam int MAX_REPORTS = 40;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic valid;
    logic runl;
    logic done;
  } vol_vert_t;

  typedef enum {ROW_PRED, ROW_ORIGIN, ROW_MARKER, ROW_SILENT} row_kind_t;

  typedef struct {
    int c[9];
    logic last;
    row_kind_t kind;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [9*COORD_W-1:0] in_tdata;
  logic in_tlast;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [3*OUT_W-1:0] out_tdata;
  logic out_tlast;
  logic [1:0] out_tuser;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  shadow_volume_extruder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // shadow copy of the light setup
  logic signed [LIGHT_W-1:0] light_cfg [3];
  logic [DIST_W-1:0] dist_cfg;

  vol_vert_t vol_queue [$];
  int err_count = 0;
  int n_tris = 0;
  int n_extruded = 0;
  int n_culled = 0;
  int n_markers = 0;
  int n_verts = 0;
  int n_setups = 1;
  int idle_cycles = 0;
  int stall_left = 0;
  bit calm = 0;

  // degenerate, culled, dot-exactly-zero and extreme triangles under the reset light
  dir_row_t dir_rows [14] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, ROW_ORIGIN},
    '{'{0, 0, 0, 0, 0, 4096, 0, 4096, 0}, 1'b0, ROW_SILENT},
    '{'{0, 0, 0, 0, 0, 4096, 0, 4096, 0}, 1'b1, ROW_MARKER},
    '{'{LO, LO, LO, LO, LO, HI, LO, HI, LO}, 1'b1, ROW_MARKER},
    '{'{LO, LO, LO, LO, LO, HI, LO, HI, LO}, 1'b0, ROW_SILENT},
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, ROW_PRED},
    '{'{HI, HI, HI, HI, HI, HI, HI, HI, HI}, 1'b0, ROW_PRED},
    '{'{LO, LO, LO, LO, LO, LO, LO, LO, LO}, 1'b1, ROW_PRED},
    '{'{0, 0, 0, 0, HI, 0, 0, 0, HI}, 1'b0, ROW_PRED},
    '{'{0, 0, 0, HI, 0, 0, 0, HI, 0}, 1'b1, ROW_PRED},
    '{'{LO, HI, LO, HI, LO, HI, LO, LO, HI}, 1'b0, ROW_PRED},
    '{'{'hAAAAAA, 'hAAAAAA, 'hAAAAAA, 'h555555, 'h555555, 'h555555, -1, -1, -1},
      1'b0, ROW_PRED},
    '{'{HI, LO, HI, LO, HI, LO, HI, HI, LO}, 1'b0, ROW_PRED},
    '{'{-1, -1, -1, 1, 1, 1, 0, 0, -1}, 1'b1, ROW_PRED}
  };

  int setups [5][4] = '{
    '{32767, 0, 0, 65535},
    '{-32768, -32768, -32768, 0},
    '{0, 0, 0, 1},
    '{0, 32767, -32768, 40000},
    '{-23170, 12000, -30000, 7}
  };

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS)
      $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [OUT_W-1:0] got,
                             input logic [OUT_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("vertex %0d %s got %0d want %0d", n_verts, name,
                                $signed(got), $signed(want)));
  endtask

  task automatic add_expected(input logic signed [OUT_W-1:0] x,
                              input logic signed [OUT_W-1:0] y,
                              input logic signed [OUT_W-1:0] z, input logic valid,
                              input logic runl, input logic done);
    vol_vert_t vv;
    vv.x = x;
    vv.y = y;
    vv.z = z;
    vv.valid = valid;
    vv.runl = runl;
    vv.done = done;
    vol_queue = {vol_queue, vv};
  endtask

  // back-face test on the exact normal, then three quads of six vertices each
  task automatic predict_volume(input tri_t t, input logic last);
    logic signed [COORD_W-1:0] p [3][3];
    logic signed [COORD_W:0] d1 [3];
    logic signed [COORD_W:0] d2 [3];
    logic signed [NORM_W:0] nrm [3];
    logic signed [71:0] dot;
    logic signed [33:0] prod;
    logic signed [33:0] off [3];
    logic signed [OUT_W-1:0] ext [3][3];
    logic fin;
    int v, c, a, b;
    for (v = 0; v < 3; v++)
      for (c = 0; c < 3; c++)
        p[v][c] = t[COORD_W*(3*v+c) +: COORD_W];
    for (c = 0; c < 3; c++) begin
      d1[c] = (COORD_W+1)'(p[2][c]) - (COORD_W+1)'(p[1][c]);
      d2[c] = (COORD_W+1)'(p[1][c]) - (COORD_W+1)'(p[0][c]);
    end
    nrm[0] = (NORM_W+1)'(d1[1]) * (NORM_W+1)'(d2[2])
           - (NORM_W+1)'(d1[2]) * (NORM_W+1)'(d2[1]);
    nrm[1] = (NORM_W+1)'(d1[2]) * (NORM_W+1)'(d2[0])
           - (NORM_W+1)'(d1[0]) * (NORM_W+1)'(d2[2]);
    nrm[2] = (NORM_W+1)'(d1[0]) * (NORM_W+1)'(d2[1])
           - (NORM_W+1)'(d1[1]) * (NORM_W+1)'(d2[0]);
    dot = 72'(nrm[0]) * 72'(light_cfg[0]) + 72'(nrm[1]) * 72'(light_cfg[1])
        + 72'(nrm[2]) * 72'(light_cfg[2]);
    if (dot > 0) begin
      n_culled++;
      if (last) begin
        n_markers++;
        add_expected(0, 0, 0, 1'b0, 1'b1, 1'b1);
      end
    end else begin
      n_extruded++;
      for (c = 0; c < 3; c++) begin
        prod = 34'(light_cfg[c]) * 34'($signed({1'b0, dist_cfg}));
        // Q.15 -> Q.12, round half up
        off[c] = (prod + 34'sd4) >>> 3;
      end
      for (v = 0; v < 3; v++)
        for (c = 0; c < 3; c++)
          ext[v][c] = OUT_W'(p[v][c] - off[c]);
      for (v = 0; v < 3; v++) begin
        a = v;
        b = (v + 1) % 3;
        fin = (v == 2);
        add_expected(p[a][0], p[a][1], p[a][2], 1'b1, 1'b0, 1'b0);
        add_expected(p[b][0], p[b][1], p[b][2], 1'b1, 1'b0, 1'b0);
        add_expected(ext[a][0], ext[a][1], ext[a][2], 1'b1, 1'b0, 1'b0);
        add_expected(p[b][0], p[b][1], p[b][2], 1'b1, 1'b0, 1'b0);
        add_expected(ext[b][0], ext[b][1], ext[b][2], 1'b1, 1'b0, 1'b0);
        add_expected(ext[a][0], ext[a][1], ext[a][2], 1'b1, fin, fin & last);
      end
    end
  endtask

  // returns once the item is taken
  task automatic send_tri(input tri_t t, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_tris++;
  endtask

  task automatic drain_and_settle();
    in_tvalid <= 1'b0;
    while (vol_queue.size() != 0) @(posedge clk);
    // culled items give no result but may still sit in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LIGHT_X:  light_cfg[0] = val;
      CFG_LIGHT_Y:  light_cfg[1] = val;
      CFG_LIGHT_Z:  light_cfg[2] = val;
      CFG_DISTANCE: dist_cfg = val;
      default: ;
    endcase
  endtask

  function automatic tri_t rand_tri();
    tri_t t;
    logic [COORD_W-1:0] base [3];
    int span, k;
    span = 1 << $urandom_range(4, 22);
    for (k = 0; k < 3; k++)
      base[k] = COORD_W'($urandom);
    for (k = 0; k < 9; k++) begin
      if (span > 4096) begin
        case ($urandom_range(0, 5))
          0:       t[COORD_W*k +: COORD_W] = 24'h800000;
          1:       t[COORD_W*k +: COORD_W] = 24'h7FFFFF;
          default: t[COORD_W*k +: COORD_W] = COORD_W'($urandom);
        endcase
      end else begin
        // small triangle around a random point, as a mesh would give
        t[COORD_W*k +: COORD_W] =
          COORD_W'(base[k % 3] + $urandom_range(0, 2 * span) - span);
      end
    end
    return t;
  endfunction

  // random output back-pressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vol_vert_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (vol_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected vertex %0d,%0d,%0d tuser=%b tlast=%b",
                                  $signed(out_tdata[OUT_W-1:0]),
                                  $signed(out_tdata[2*OUT_W-1:OUT_W]),
                                  $signed(out_tdata[3*OUT_W-1:2*OUT_W]),
                                  out_tuser, out_tlast));
      end else begin
        want = vol_queue.pop_front();
        check_field("x", out_tdata[OUT_W-1:0], want.x);
        check_field("y", out_tdata[2*OUT_W-1:OUT_W], want.y);
        check_field("z", out_tdata[3*OUT_W-1:2*OUT_W], want.z);
        check_field("vertex_valid", OUT_W'(out_tuser[0]), OUT_W'(want.valid));
        check_field("mesh_done", OUT_W'(out_tuser[1]), OUT_W'(want.done));
        check_field("run_last", OUT_W'(out_tlast), OUT_W'(want.runl));
      end
      n_verts++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: nothing moved for %0d cycles, %0d vertices outstanding",
                 idle_cycles, vol_queue.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    tri_t t;
    logic lst;
    int i, ph, k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_LIGHT_X;
    cfg_wdata = '0;
    light_cfg[0] = LIGHT_X_RST;
    light_cfg[1] = LIGHT_Y_RST;
    light_cfg[2] = LIGHT_Z_RST;
    dist_cfg = DIST_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < 14; i++) begin
      for (k = 0; k < 9; k++)
        t[COORD_W*k +: COORD_W] = dir_rows[i].c[k][COORD_W-1:0];
      send_tri(t, dir_rows[i].last);
      case (dir_rows[i].kind)
        ROW_ORIGIN: begin
          // all corners at the origin; extruded copy sits at -offset of the reset light
          n_extruded++;
          for (k = 0; k < 3; k++) begin
            add_expected(0, 0, 0, 1'b1, 1'b0, 1'b0);
            add_expected(0, 0, 0, 1'b1, 1'b0, 1'b0);
            add_expected(-28962500, -28962500, 0, 1'b1, 1'b0, 1'b0);
            add_expected(0, 0, 0, 1'b1, 1'b0, 1'b0);
            add_expected(-28962500, -28962500, 0, 1'b1, 1'b0, 1'b0);
            add_expected(-28962500, -28962500, 0, 1'b1, k == 2, 1'b0);
          end
        end
        ROW_MARKER: begin
          n_culled++;
          n_markers++;
          add_expected(0, 0, 0, 1'b0, 1'b1, 1'b1);
        end
        ROW_SILENT: n_culled++;
        default: predict_volume(t, dir_rows[i].last);
      endcase
    end

    for (ph = 0; ph < 6; ph++) begin
      drain_and_settle();
      if (ph < 5) begin
        write_reg(CFG_LIGHT_X, setups[ph][0][CFG_DW-1:0]);
        write_reg(CFG_LIGHT_Y, setups[ph][1][CFG_DW-1:0]);
        write_reg(CFG_LIGHT_Z, setups[ph][2][CFG_DW-1:0]);
        write_reg(CFG_DISTANCE, setups[ph][3][CFG_DW-1:0]);
      end else begin
        write_reg(CFG_LIGHT_X, CFG_DW'($urandom_range(0, 65535)));
        write_reg(CFG_LIGHT_Y, CFG_DW'($urandom_range(0, 65535)));
        write_reg(CFG_LIGHT_Z, CFG_DW'($urandom_range(0, 65535)));
        write_reg(CFG_DISTANCE, CFG_DW'($urandom_range(0, 65535)));
        calm = 1;
      end
      cfg_we <= 1'b0;
      n_setups++;
      for (i = 0; i < PHASE_TRIS; i++) begin
        t = rand_tri();
        lst = ($urandom_range(0, 3) == 0);
        send_tri(t, lst);
        predict_volume(t, lst);
      end
    end

    in_tvalid <= 1'b0;
    while (vol_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d triangles under %0d light setups: %0d extruded, %0d culled, %0d markers.",
             n_tris, n_setups, n_extruded, n_culled, n_markers);
    $display("Checked %0d volume vertices, %0d mismatches.", n_verts, err_count);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
